[src/srfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srfc_pkg;

    localparam logic [7:0] FRAME_END    = 8'hC0;
    localparam logic [7:0] FRAME_ESC    = 8'hDB;
    localparam logic [7:0] ESC_FOR_END  = 8'hDC;
    localparam logic [7:0] ESC_FOR_ESC  = 8'hDD;
    localparam logic [7:0] ACK_CODE     = 8'h06;
    localparam logic [15:0] HEADER_BYTES = 16'd6;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [15:0] CAPACITY_RESET = 16'd512;

    localparam logic CFG_EXPECTED_DEVICE = 1'b0;
    localparam logic CFG_REPLY_CAPACITY  = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_LENGTH_ERR = 3'd1,
        STATUS_CHECKSUM_ERR = 3'd2,
        STATUS_WRONG_DEVICE = 3'd3,
        STATUS_NOT_ACK    = 3'd4
    } status_t;

    // Header byte positions within a frame.
    localparam logic [2:0] POS_DEVICE   = 3'd0;
    localparam logic [2:0] POS_COMMAND  = 3'd1;
    localparam logic [2:0] POS_LEN_LOW  = 3'd2;
    localparam logic [2:0] POS_LEN_HIGH = 3'd3;
    localparam logic [2:0] POS_CHECKSUM = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [15:0] length;
        logic        last;
    } result_t;

    // One's-complement style add: the carry out wraps back into bit 0.
    function automatic logic [7:0] eac_add(input logic [7:0] sum, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, sum} + {1'b0, b};
        return t[7:0] + {7'd0, t[8]};
    endfunction

endpackage

`default_nettype wire

[src/srfc_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

module srfc_decoder (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      rx_byte,
    input  wire logic [7:0]      expected_device,
    input  wire logic [15:0]     reply_capacity,
    output logic                 res_valid,
    output srfc_pkg::result_t    res
);

    logic        escape_pending_reg, escape_pending_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  header_device_reg, header_device_next;
    logic [7:0]  header_command_reg, header_command_next;
    logic [15:0] header_length_reg, header_length_next;
    logic [7:0]  header_checksum_reg, header_checksum_next;
    logic        overflow_seen_reg, overflow_seen_next;

    logic        have_byte;
    logic [7:0]  decoded;
    logic [15:0] payload_pos;
    logic [2:0]  status;

    always_comb
    begin
        priority if (byte_count_reg < srfc_pkg::HEADER_BYTES
                     || byte_count_reg != header_length_reg || overflow_seen_reg)
            status = srfc_pkg::STATUS_LENGTH_ERR;
        else if (running_sum_reg != header_checksum_reg)
            status = srfc_pkg::STATUS_CHECKSUM_ERR;
        else if (header_device_reg != expected_device)
            status = srfc_pkg::STATUS_WRONG_DEVICE;
        else if (header_command_reg != srfc_pkg::ACK_CODE)
            status = srfc_pkg::STATUS_NOT_ACK;
        else
            status = srfc_pkg::STATUS_OK;
    end

    assign payload_pos = byte_count_reg - srfc_pkg::HEADER_BYTES;

    always_comb
    begin
        escape_pending_next  = escape_pending_reg;
        byte_count_next      = byte_count_reg;
        running_sum_next     = running_sum_reg;
        header_device_next   = header_device_reg;
        header_command_next  = header_command_reg;
        header_length_next   = header_length_reg;
        header_checksum_next = header_checksum_reg;
        overflow_seen_next   = overflow_seen_reg;
        have_byte = 1'b0;
        decoded   = rx_byte;
        res_valid = 1'b0;
        res.kind         = srfc_pkg::KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.status       = srfc_pkg::STATUS_OK;
        res.length       = 16'd0;
        res.last         = 1'b0;

        priority if (rx_byte == srfc_pkg::FRAME_END)
        begin
            escape_pending_next = 1'b0;
            if (byte_count_reg != 16'd0)
            begin
                res_valid  = 1'b1;
                res.kind   = srfc_pkg::KIND_VERDICT;
                res.status = status;
                res.length = byte_count_reg;
                res.last   = 1'b1;
                byte_count_next      = 16'd0;
                running_sum_next     = 8'd0;
                header_device_next   = 8'd0;
                header_command_next  = 8'd0;
                header_length_next   = 16'd0;
                header_checksum_next = 8'd0;
                overflow_seen_next   = 1'b0;
            end
        end
        else if (escape_pending_reg)
        begin
            escape_pending_next = 1'b0;
            have_byte = 1'b1;
            // An unknown escape code passes through unchanged.
            if (rx_byte == srfc_pkg::ESC_FOR_END)
                decoded = srfc_pkg::FRAME_END;
            else if (rx_byte == srfc_pkg::ESC_FOR_ESC)
                decoded = srfc_pkg::FRAME_ESC;
        end
        else if (rx_byte == srfc_pkg::FRAME_ESC)
            escape_pending_next = 1'b1;
        else
            have_byte = 1'b1;

        if (have_byte)
        begin
            priority if (byte_count_reg == srfc_pkg::COUNT_MAX)
                overflow_seen_next = 1'b1;
            else if (byte_count_reg < srfc_pkg::HEADER_BYTES)
            begin
                byte_count_next = byte_count_reg + 16'd1;
                unique case (byte_count_reg[2:0])
                    srfc_pkg::POS_DEVICE:   header_device_next = decoded;
                    srfc_pkg::POS_COMMAND:  header_command_next = decoded;
                    srfc_pkg::POS_LEN_LOW:  header_length_next[7:0] = decoded;
                    srfc_pkg::POS_LEN_HIGH: header_length_next[15:8] = decoded;
                    srfc_pkg::POS_CHECKSUM: header_checksum_next = decoded;
                    default: ;
                endcase
                // The checksum byte itself counts as zero in the sum.
                if (byte_count_reg[2:0] != srfc_pkg::POS_CHECKSUM)
                    running_sum_next = srfc_pkg::eac_add(running_sum_reg, decoded);
            end
            else if (payload_pos >= reply_capacity)
            begin
                byte_count_next    = byte_count_reg + 16'd1;
                overflow_seen_next = 1'b1;
            end
            else
            begin
                byte_count_next  = byte_count_reg + 16'd1;
                running_sum_next = srfc_pkg::eac_add(running_sum_reg, decoded);
                res_valid        = 1'b1;
                res.payload_byte = decoded;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg  <= 1'b0;
            byte_count_reg      <= 16'd0;
            running_sum_reg     <= 8'd0;
            header_device_reg   <= 8'd0;
            header_command_reg  <= 8'd0;
            header_length_reg   <= 16'd0;
            header_checksum_reg <= 8'd0;
            overflow_seen_reg   <= 1'b0;
        end
        else if (accept)
        begin
            escape_pending_reg  <= escape_pending_next;
            byte_count_reg      <= byte_count_next;
            running_sum_reg     <= running_sum_next;
            header_device_reg   <= header_device_next;
            header_command_reg  <= header_command_next;
            header_length_reg   <= header_length_next;
            header_checksum_reg <= header_checksum_next;
            overflow_seen_reg   <= overflow_seen_next;
        end
    end

endmodule

`default_nettype wire

[src/srfc_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module srfc_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire srfc_pkg::result_t  push_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output srfc_pkg::result_t       out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    srfc_pkg::result_t main_data_reg, main_data_next;
    srfc_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop       = main_valid_reg && !out_stall;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    // The skid entry only fills while the main entry is stalled, so a full
    // buffer is the one case where a new request must wait.
    assign full      = skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (pop)
            main_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

[src/slip_reply_frame_checker.sv]
// A result is registered in the output buffer before it appears on the output.
// Throughput: one raw byte per cycle; each byte updates the frame state in a
// single pass between the frame registers and a two-entry output buffer.
// Input stalls only while both output entries hold results not yet taken.
// Reset (rst_n low, asynchronous): frame state cleared, output buffer empty,
// expected_device = 0, reply_capacity = 512.
`timescale 1ns / 1ps
`default_nettype none

module slip_reply_frame_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic [7:0]       payload_byte,
    output logic [2:0]       frame_status,
    output logic [15:0]      frame_length,
    output logic             is_last,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [7:0]        expected_device_reg;
    logic [15:0]       reply_capacity_reg;
    logic              accept;
    logic              res_valid;
    logic              buf_full;
    srfc_pkg::result_t res;
    srfc_pkg::result_t out_data;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_device_reg <= 8'd0;
            reply_capacity_reg  <= srfc_pkg::CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srfc_pkg::CFG_EXPECTED_DEVICE: expected_device_reg <= cfg_data[7:0];
                srfc_pkg::CFG_REPLY_CAPACITY:  reply_capacity_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    srfc_decoder u_decoder (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .rx_byte         (rx_byte),
        .expected_device (expected_device_reg),
        .reply_capacity  (reply_capacity_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    srfc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign result_kind  = out_data.kind;
    assign payload_byte = out_data.payload_byte;
    assign frame_status = out_data.status;
    assign frame_length = out_data.length;
    assign is_last      = out_data.last;

`ifndef NO_ASSERTIONS
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    a_verdict_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> is_last && payload_byte == 8'd0
            && frame_length != 16'd0)
        else $error("malformed verdict");

    a_payload_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |-> !is_last && frame_status == 3'd0
            && frame_length == 16'd0)
        else $error("malformed payload result");
`endif

endmodule

`default_nettype wire
